// ===== design/tile_map_pixel_renderer_unit_defines.svh =====
// assertion macros for the tile map pixel renderer
`ifndef TILE_MAP_PIXEL_RENDERER_UNIT_DEFINES_SVH
`define TILE_MAP_PIXEL_RENDERER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// condition holds in the same cycle as the trigger
`define TMPR_ASSERT_SAME(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
		else $error("tmpr assertion failed");

// condition holds in the cycle after the trigger
`define TMPR_ASSERT_NEXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
		else $error("tmpr assertion failed");

`else

`define TMPR_ASSERT_SAME(label, clk, rst_n, trig, cond)
`define TMPR_ASSERT_NEXT(label, clk, rst_n, trig, cond)

`endif

`endif

// ===== design/tmpr_pkg.sv =====
// shared constants and types of the tile map pixel renderer
package tmpr_pkg;

	// default memory sizes in bytes
	localparam int unsigned BANK_ONE_BYTES_DEF   = 512;
	localparam int unsigned BANK_TWO_BYTES_DEF   = 2048;
	localparam int unsigned BANK_THREE_BYTES_DEF = 2048;
	localparam int unsigned MAP_BYTES_DEF        = 8192;

	// field widths
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned ADDR_W   = 13;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned SCR_W    = 8;
	localparam int unsigned COLOR_W  = 16;
	localparam int unsigned CAM_W    = 12;
	localparam int unsigned WORLD_W  = 13;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	// wide enough for any address compare against a size up to 65536
	localparam int unsigned CMP_W    = 17;

	// map layout
	localparam int unsigned LAYOUT_BASE = 4060;
	localparam int unsigned LAYOUT_ROW  = 54;
	localparam int unsigned SCREEN_H    = 192;

	// tile bank boundaries
	localparam int unsigned TILE_BANK_TWO_LO   = 45;
	localparam int unsigned TILE_BANK_THREE_LO = 139;
	localparam int unsigned TILE_BANK_TWO_HI   = 204;

	localparam logic [COLOR_W-1:0] DRAW_COLOR_RST = 16'h7FFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_BANK_ONE   = 3'd0,
		CMD_BANK_TWO   = 3'd1,
		CMD_BANK_THREE = 3'd2,
		CMD_MAP        = 3'd3,
		CMD_RENDER     = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAM_X      = 2'd0,
		CFG_CAM_Y      = 2'd1,
		CFG_DRAW_COLOR = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		SEL_ONE   = 2'd0,
		SEL_TWO   = 2'd1,
		SEL_THREE = 2'd2
	} bank_sel_t;

endpackage

// ===== design/tmpr_ram.sv =====
// byte memory with one write port and one registered read port
module tmpr_ram #(
	parameter int unsigned DEPTH = tmpr_pkg::BANK_ONE_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       rd_en,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [tmpr_pkg::BYTE_W-1:0] rd_data,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [tmpr_pkg::BYTE_W-1:0] wr_data
);
	import tmpr_pkg::*;

	logic [BYTE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== design/tile_map_pixel_renderer_unit.sv =====
// top level of the tile map pixel renderer
//
// usage
//   request channel (req_valid / req_stall) carries one command per transaction:
//   a byte write to bank one, two or three or to the map memory, or a pixel
//   to render. every request gives exactly one response transaction on
//   rsp_valid / rsp_stall: the rendered pixel and hit flag, or zeros for writes
//   and unused commands.
//   a request passes the stage registers s1 to s4 and the response register s5
//   before rsp_valid; while no response is stalled, one request per cycle is taken
//   and one response per cycle is delivered, so throughput is one pixel a cycle.
//   the pipeline runs as one unit: every stage moves when the response register
//   is empty or being taken.
//   a stalled response freezes the whole pipeline and req_stall goes high in
//   the same cycle; nothing is lost or repeated.
//   cam_x, cam_y and draw_color are written through cfg_write / cfg_index /
//   cfg_data while no request is in flight.
//   reset clears the pipeline valids and sets the registers to their defaults;
//   memory contents are undefined until written, no clearing pass is run.
`include "tile_map_pixel_renderer_unit_defines.svh"

module tile_map_pixel_renderer_unit #(
	parameter int unsigned BANK_ONE_BYTES   = tmpr_pkg::BANK_ONE_BYTES_DEF,
	parameter int unsigned BANK_TWO_BYTES   = tmpr_pkg::BANK_TWO_BYTES_DEF,
	parameter int unsigned BANK_THREE_BYTES = tmpr_pkg::BANK_THREE_BYTES_DEF,
	parameter int unsigned MAP_BYTES        = tmpr_pkg::MAP_BYTES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_write,
	input  logic [tmpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tmpr_pkg::CFG_DATA_W-1:0] cfg_data,
	// request channel
	input  logic                           req_valid,
	output logic                           req_stall,
	input  logic [tmpr_pkg::CMD_W-1:0]      command,
	input  logic [tmpr_pkg::ADDR_W-1:0]     address,
	input  logic [tmpr_pkg::BYTE_W-1:0]     data,
	input  logic [tmpr_pkg::SCR_W-1:0]      pixel_x,
	input  logic [tmpr_pkg::SCR_W-1:0]      pixel_y,
	input  logic [tmpr_pkg::COLOR_W-1:0]    background_pixel,
	// response channel
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output logic [tmpr_pkg::COLOR_W-1:0]    pixel_out,
	output logic                           tile_hit
);
	import tmpr_pkg::*;

	localparam int unsigned MAP_AW = $clog2(MAP_BYTES);
	localparam int unsigned B1_AW  = $clog2(BANK_ONE_BYTES);
	localparam int unsigned B2_AW  = $clog2(BANK_TWO_BYTES);
	localparam int unsigned B3_AW  = $clog2(BANK_THREE_BYTES);
	// tile index and row: 8 + 3 bits
	localparam int unsigned TA_W   = BYTE_W + 3;

	// configuration registers
	logic [CAM_W-1:0]   cam_x_q;
	logic [CAM_W-1:0]   cam_y_q;
	logic [COLOR_W-1:0] draw_color_q;

	// whole pipeline advances together
	logic adv;

	// stage 1: captured request plus world position
	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic [BYTE_W-1:0]  data_s1;
	logic [WORLD_W-1:0] wx_s1;
	logic [WORLD_W-1:0] wy_s1;
	logic               offscr_s1;
	logic [COLOR_W-1:0] bg_s1;

	// stage 2: layout byte read
	logic               valid_s2;
	logic [CMD_W-1:0]   cmd_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic [BYTE_W-1:0]  data_s2;
	logic [4:0]         wx_s2;
	logic [4:0]         wy_s2;
	logic               miss_s2;
	logic [COLOR_W-1:0] bg_s2;
	logic [BYTE_W-1:0]  st_s2;

	// stage 3: tile index read
	logic               valid_s3;
	logic [CMD_W-1:0]   cmd_s3;
	logic [ADDR_W-1:0]  addr_s3;
	logic [BYTE_W-1:0]  data_s3;
	logic [2:0]         col_s3;
	logic [2:0]         row_s3;
	logic               miss_s3;
	logic [COLOR_W-1:0] bg_s3;
	logic [BYTE_W-1:0]  tile_s3;

	// stage 4: tile row bytes read
	logic               valid_s4;
	logic [CMD_W-1:0]   cmd_s4;
	logic [2:0]         col_s4;
	logic               miss_s4;
	bank_sel_t          sel_s4;
	logic [COLOR_W-1:0] bg_s4;
	logic [BYTE_W-1:0]  b1_s4;
	logic [BYTE_W-1:0]  b2_s4;
	logic [BYTE_W-1:0]  b3_s4;

	// stage 5: response register
	logic               valid_s5;
	logic [COLOR_W-1:0] pixel_out_s5;
	logic               tile_hit_s5;

	assign adv       = !(valid_s5 && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = valid_s5;
	assign pixel_out = pixel_out_s5;
	assign tile_hit  = tile_hit_s5;

	// configuration writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q      <= '0;
			cam_y_q      <= '0;
			draw_color_q <= DRAW_COLOR_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_CAM_X:      cam_x_q      <= cfg_data[CAM_W-1:0];
				CFG_CAM_Y:      cam_y_q      <= cfg_data[CAM_W-1:0];
				CFG_DRAW_COLOR: draw_color_q <= cfg_data[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= req_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// ---------------- stage 1: world position ----------------
	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1    <= command;
			addr_s1   <= address;
			data_s1   <= data;
			wx_s1     <= WORLD_W'(cam_x_q) + WORLD_W'(pixel_x);
			wy_s1     <= WORLD_W'(cam_y_q) + WORLD_W'(pixel_y);
			offscr_s1 <= (pixel_y >= SCR_W'(SCREEN_H));
			bg_s1     <= background_pixel;
		end
	end

	// ---------------- stage 1 -> 2: layout lookup ----------------
	logic [CMP_W-1:0] layout_addr;
	logic             cell_ok;
	logic             render_s1;
	logic             map_wr_s1;

	assign layout_addr = CMP_W'(LAYOUT_BASE) + CMP_W'(wx_s1[WORLD_W-1:5])
		+ CMP_W'(wy_s1[WORLD_W-1:5]) * CMP_W'(LAYOUT_ROW);
	assign cell_ok   = layout_addr < CMP_W'(MAP_BYTES);
	assign render_s1 = valid_s1 && (cmd_s1 == CMD_RENDER);
	assign map_wr_s1 = adv && valid_s1 && (cmd_s1 == CMD_MAP)
		&& (CMP_W'(addr_s1) < CMP_W'(MAP_BYTES));

	// layout copy of the map memory, written as writes pass this stage so a
	// render behind a write sees it and one ahead does not
	tmpr_ram #(.DEPTH(MAP_BYTES)) u_map_layout (
		.clk     (clk),
		.rd_en   (adv && render_s1 && cell_ok),
		.rd_addr (MAP_AW'(layout_addr)),
		.rd_data (st_s2),
		.wr_en   (map_wr_s1),
		.wr_addr (MAP_AW'(addr_s1)),
		.wr_data (data_s1)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s2  <= cmd_s1;
			addr_s2 <= addr_s1;
			data_s2 <= data_s1;
			wx_s2   <= wx_s1[4:0];
			wy_s2   <= wy_s1[4:0];
			miss_s2 <= offscr_s1 || !cell_ok;
			bg_s2   <= bg_s1;
		end
	end

	// ---------------- stage 2 -> 3: supertile definition ----------------
	// definition byte: supertile * 16 + quad row * 4 + quad column
	logic [BYTE_W+3:0] def_addr;
	logic              def_ok;
	logic              render_s2;
	logic              map_wr_s2;

	assign def_addr  = {st_s2, wy_s2[4:3], wx_s2[4:3]};
	assign def_ok    = CMP_W'(def_addr) < CMP_W'(MAP_BYTES);
	assign render_s2 = valid_s2 && (cmd_s2 == CMD_RENDER);
	assign map_wr_s2 = adv && valid_s2 && (cmd_s2 == CMD_MAP)
		&& (CMP_W'(addr_s2) < CMP_W'(MAP_BYTES));

	// definition copy of the map memory
	tmpr_ram #(.DEPTH(MAP_BYTES)) u_map_def (
		.clk     (clk),
		.rd_en   (adv && render_s2 && !miss_s2 && def_ok),
		.rd_addr (MAP_AW'(def_addr)),
		.rd_data (tile_s3),
		.wr_en   (map_wr_s2),
		.wr_addr (MAP_AW'(addr_s2)),
		.wr_data (data_s2)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s3  <= cmd_s2;
			addr_s3 <= addr_s2;
			data_s3 <= data_s2;
			col_s3  <= wx_s2[2:0];
			row_s3  <= wy_s2[2:0];
			miss_s3 <= miss_s2 || !def_ok;
			bg_s3   <= bg_s2;
		end
	end

	// ---------------- stage 3 -> 4: tile row bytes ----------------
	logic [TA_W-1:0]  tile_addr;
	bank_sel_t        sel;
	logic             row_ok;
	logic             bank_wr;

	assign tile_addr = {tile_s3, row_s3};
	assign bank_wr   = adv && valid_s3;

	// bank choice by tile index range, top range folds back to bank two
	always_comb begin
		if (tile_s3 < BYTE_W'(TILE_BANK_TWO_LO)) begin
			sel = SEL_ONE;
		end else if (tile_s3 < BYTE_W'(TILE_BANK_THREE_LO)
				|| tile_s3 >= BYTE_W'(TILE_BANK_TWO_HI)) begin
			sel = SEL_TWO;
		end else begin
			sel = SEL_THREE;
		end
	end

	always_comb begin
		case (sel)
			SEL_ONE:   row_ok = CMP_W'(tile_addr) < CMP_W'(BANK_ONE_BYTES);
			SEL_TWO:   row_ok = CMP_W'(tile_addr) < CMP_W'(BANK_TWO_BYTES);
			SEL_THREE: row_ok = CMP_W'(tile_addr) < CMP_W'(BANK_THREE_BYTES);
			default:   row_ok = 1'b0;
		endcase
	end

	tmpr_ram #(.DEPTH(BANK_ONE_BYTES)) u_bank_one (
		.clk     (clk),
		.rd_en   (adv && sel == SEL_ONE && row_ok),
		.rd_addr (B1_AW'(tile_addr)),
		.rd_data (b1_s4),
		.wr_en   (bank_wr && (cmd_s3 == CMD_BANK_ONE)
			&& (CMP_W'(addr_s3) < CMP_W'(BANK_ONE_BYTES))),
		.wr_addr (B1_AW'(addr_s3)),
		.wr_data (data_s3)
	);

	tmpr_ram #(.DEPTH(BANK_TWO_BYTES)) u_bank_two (
		.clk     (clk),
		.rd_en   (adv && sel == SEL_TWO && row_ok),
		.rd_addr (B2_AW'(tile_addr)),
		.rd_data (b2_s4),
		.wr_en   (bank_wr && (cmd_s3 == CMD_BANK_TWO)
			&& (CMP_W'(addr_s3) < CMP_W'(BANK_TWO_BYTES))),
		.wr_addr (B2_AW'(addr_s3)),
		.wr_data (data_s3)
	);

	tmpr_ram #(.DEPTH(BANK_THREE_BYTES)) u_bank_three (
		.clk     (clk),
		.rd_en   (adv && sel == SEL_THREE && row_ok),
		.rd_addr (B3_AW'(tile_addr)),
		.rd_data (b3_s4),
		.wr_en   (bank_wr && (cmd_s3 == CMD_BANK_THREE)
			&& (CMP_W'(addr_s3) < CMP_W'(BANK_THREE_BYTES))),
		.wr_addr (B3_AW'(addr_s3)),
		.wr_data (data_s3)
	);

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s4  <= cmd_s3;
			col_s4  <= col_s3;
			miss_s4 <= miss_s3 || !row_ok;
			sel_s4  <= sel;
			bg_s4   <= bg_s3;
		end
	end

	// ---------------- stage 4 -> 5: bit test and response ----------------
	logic [BYTE_W-1:0] row_bits;
	logic              render_s4;
	logic              hit;

	always_comb begin
		case (sel_s4)
			SEL_ONE:   row_bits = b1_s4;
			SEL_TWO:   row_bits = b2_s4;
			SEL_THREE: row_bits = b3_s4;
			default:   row_bits = '0;
		endcase
	end

	// msb first: column c tests bit 7 - c, which is the inverted column
	assign render_s4 = (cmd_s4 == CMD_RENDER);
	assign hit       = render_s4 && !miss_s4 && row_bits[~col_s4];

	always_ff @(posedge clk) begin
		if (adv) begin
			tile_hit_s5 <= hit;
			if (hit) begin
				pixel_out_s5 <= draw_color_q;
			end else if (render_s4) begin
				pixel_out_s5 <= bg_s4;
			end else begin
				pixel_out_s5 <= '0;
			end
		end
	end

	// ---------------- checks ----------------
	// a frozen pipeline keeps stage 4 occupied
	`TMPR_ASSERT_NEXT(a_hold_s4, clk, arst_n, valid_s4 && !adv, valid_s4)
	// an advancing stage hands its transaction on
	`TMPR_ASSERT_NEXT(a_move_s1, clk, arst_n, valid_s1 && adv, valid_s2)
	// a hit always carries the draw colour
	`TMPR_ASSERT_SAME(a_hit_color, clk, arst_n, valid_s5 && tile_hit_s5,
		pixel_out_s5 == draw_color_q)

endmodule

// ===== tb/tile_map_pixel_renderer_unit_test.sv =====
// self-checking testbench for the tile map pixel renderer: shadow memories, pixel lookup, checks
module tile_map_pixel_renderer_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tmpr_pkg::*;

	// unused command codes, the block answers them with zeros
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	// settle wait after a drain, longer than the request to response path, before touching registers
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_LIMIT   = 10000;
	localparam int unsigned HOLD_CYCLES   = 80;
	localparam int unsigned RUN_LIMIT_NS  = 5_000_000;
	localparam int unsigned PRINT_LIMIT   = 100;

	// one expected response transaction
	typedef struct packed {
		logic [COLOR_W-1:0] pixel;
		logic               hit;
	} pixel_result_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_write;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  req_valid;
	logic                  req_stall;
	logic [CMD_W-1:0]      command;
	logic [ADDR_W-1:0]     address;
	logic [BYTE_W-1:0]     data;
	logic [SCR_W-1:0]      pixel_x;
	logic [SCR_W-1:0]      pixel_y;
	logic [COLOR_W-1:0]    background_pixel;
	logic                  rsp_valid;
	logic                  rsp_stall;
	logic [COLOR_W-1:0]    pixel_out;
	logic                  tile_hit;

	// shadow of the four memories, indexed by the write command that fills them
	logic [BYTE_W-1:0] mem_mirror [4][MAP_BYTES_DEF];
	bit                mem_loaded [4][MAP_BYTES_DEF];

	// shadow of the configuration registers, reset values
	logic [CAM_W-1:0]   cam_x_q  = '0;
	logic [CAM_W-1:0]   cam_y_q  = '0;
	logic [COLOR_W-1:0] colour_q = DRAW_COLOR_RST;

	// responses still owed by the block, oldest first
	pixel_result_t pending_pixels [$];
	pixel_result_t oldest_expected;

	int unsigned mismatch_count     = 0;
	int unsigned items_sent         = 0;
	bit          sender_gaps_on     = 1'b0;
	bit          receiver_stalls_on = 1'b0;
	// long receiver hold-off, picked up and counted down by the response side
	int unsigned hold_request       = 0;

	tile_map_pixel_renderer_unit u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.command          (command),
		.address          (address),
		.data             (data),
		.pixel_x          (pixel_x),
		.pixel_y          (pixel_y),
		.background_pixel (background_pixel),
		.rsp_valid        (rsp_valid),
		.rsp_stall        (rsp_stall),
		.pixel_out        (pixel_out),
		.tile_hit         (tile_hit)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// mostly no gap, sometimes a few cycles, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic int unsigned mem_bytes(input logic [CMD_W-1:0] target);
		case (target)
			CMD_BANK_ONE:   return BANK_ONE_BYTES_DEF;
			CMD_BANK_TWO:   return BANK_TWO_BYTES_DEF;
			CMD_BANK_THREE: return BANK_THREE_BYTES_DEF;
			default:        return MAP_BYTES_DEF;
		endcase
	endfunction

	// bank two serves both the middle range and the top of the index space
	function automatic logic [CMD_W-1:0] bank_for_tile(input int unsigned tile);
		if (tile < TILE_BANK_TWO_LO)
			return CMD_BANK_ONE;
		if (tile < TILE_BANK_THREE_LO || tile >= TILE_BANK_TWO_HI)
			return CMD_BANK_TWO;
		return CMD_BANK_THREE;
	endfunction

	// walks layout, supertile and tile row for one screen pixel; returns 1 and names the
	// first byte on the path that has never been loaded, otherwise gives the hit flag
	function automatic bit trace_lookup(input logic [SCR_W-1:0] px, input logic [SCR_W-1:0] py,
			output logic hit, output logic [CMD_W-1:0] gap_target,
			output int unsigned gap_addr);
		int unsigned       wx, wy, cell_addr, supertile, def_addr, tile, row_addr;
		logic [CMD_W-1:0]  bank;
		logic [BYTE_W-1:0] row_bits;
		hit = 1'b0;
		gap_target = CMD_MAP;
		gap_addr = 0;
		if (py >= SCREEN_H)
			return 1'b0;
		wx = cam_x_q + px;
		wy = cam_y_q + py;
		// 32 by 32 pixel supertile cells
		cell_addr = LAYOUT_BASE + (wx >> 5) + (wy >> 5) * LAYOUT_ROW;
		if (cell_addr >= MAP_BYTES_DEF)
			return 1'b0;
		if (!mem_loaded[CMD_MAP][cell_addr]) begin
			gap_addr = cell_addr;
			return 1'b1;
		end
		// 16 tile indices per supertile, 4 by 4, row major
		supertile = mem_mirror[CMD_MAP][cell_addr];
		def_addr = supertile * 16 + ((wx % 32) >> 3) + ((wy % 32) >> 3) * 4;
		if (supertile * 16 >= MAP_BYTES_DEF || def_addr >= MAP_BYTES_DEF)
			return 1'b0;
		if (!mem_loaded[CMD_MAP][def_addr]) begin
			gap_addr = def_addr;
			return 1'b1;
		end
		tile = mem_mirror[CMD_MAP][def_addr];
		bank = bank_for_tile(tile);
		row_addr = tile * 8 + (wy % 8);
		if (tile * 8 >= mem_bytes(bank) || row_addr >= mem_bytes(bank))
			return 1'b0;
		if (!mem_loaded[bank][row_addr]) begin
			gap_target = bank;
			gap_addr = row_addr;
			return 1'b1;
		end
		// leftmost pixel is the top bit
		row_bits = mem_mirror[bank][row_addr];
		hit = row_bits[7 - (wx % 8)];
		return 1'b0;
	endfunction

	// updates the shadow state for one accepted request and gives the response it owes
	function automatic pixel_result_t apply_command(input logic [CMD_W-1:0] op,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] byte_in,
			input logic [SCR_W-1:0] px, input logic [SCR_W-1:0] py,
			input logic [COLOR_W-1:0] bg);
		pixel_result_t     res;
		logic              hit;
		logic [CMD_W-1:0]  gap_target;
		int unsigned       gap_addr;
		res = '0;
		case (op)
			CMD_BANK_ONE, CMD_BANK_TWO, CMD_BANK_THREE, CMD_MAP: begin
				// writes past the end of the target are dropped
				if (addr < mem_bytes(op)) begin
					mem_mirror[op][addr] = byte_in;
					mem_loaded[op][addr] = 1'b1;
				end
			end
			CMD_RENDER: begin
				void'(trace_lookup(px, py, hit, gap_target, gap_addr));
				res.hit = hit;
				res.pixel = hit ? colour_q : bg;
			end
			default: ;
		endcase
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= PRINT_LIMIT)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// register writes only happen with nothing in flight
	task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
		@(negedge clk);
		cfg_write = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(posedge clk);
		case (idx)
			CFG_CAM_X:      cam_x_q = value[CAM_W-1:0];
			CFG_CAM_Y:      cam_y_q = value[CAM_W-1:0];
			CFG_DRAW_COLOR: colour_q = value;
			default: ;
		endcase
		@(negedge clk);
		cfg_write = 1'b0;
	endtask

	// one request transaction: optional gap, then hold the payload until it is taken
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [ADDR_W-1:0] addr,
			input logic [BYTE_W-1:0] byte_in, input logic [SCR_W-1:0] px,
			input logic [SCR_W-1:0] py, input logic [COLOR_W-1:0] bg);
		int unsigned idle;
		idle = sender_gaps_on ? pick_gap() : 0;
		if (idle != 0) begin
			@(negedge clk);
			req_valid = 1'b0;
			repeat (idle - 1) @(negedge clk);
		end
		@(negedge clk);
		req_valid = 1'b1;
		command = op;
		address = addr;
		data = byte_in;
		pixel_x = px;
		pixel_y = py;
		background_pixel = bg;
		do @(posedge clk); while (req_stall);
		pending_pixels.push_back(apply_command(op, addr, byte_in, px, py, bg));
		items_sent++;
	endtask

	// loads any byte the lookup would touch before it was written, then renders
	task automatic send_render(input logic [SCR_W-1:0] px, input logic [SCR_W-1:0] py,
			input logic [COLOR_W-1:0] bg);
		logic             hit;
		logic [CMD_W-1:0] gap_target;
		int unsigned      gap_addr;
		while (trace_lookup(px, py, hit, gap_target, gap_addr))
			send_item(gap_target, ADDR_W'(gap_addr), BYTE_W'($urandom_range(0, 255)),
				SCR_W'($urandom_range(0, 255)), SCR_W'($urandom_range(0, 255)),
				COLOR_W'($urandom_range(0, 65535)));
		send_item(CMD_RENDER, ADDR_W'($urandom_range(0, 8191)),
			BYTE_W'($urandom_range(0, 255)), px, py, bg);
	endtask

	// one pixel in ten lands below the visible rows
	task automatic send_random_render();
		send_render(SCR_W'($urandom_range(0, 255)),
			SCR_W'(($urandom_range(0, 9) == 0) ? $urandom_range(192, 255)
				: $urandom_range(0, 191)),
			COLOR_W'($urandom_range(0, 65535)));
	endtask

	// stop offering, wait for every owed response, then let the pipe settle
	task automatic drain_pipeline();
		int unsigned waited;
		waited = 0;
		@(negedge clk);
		req_valid = 1'b0;
		while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_pixels.size() != 0) begin
			report_mismatch($sformatf("%0d responses never arrived", pending_pixels.size()));
			pending_pixels.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// reset registers: first layout cell points at supertile zero, its first entry is
	// switched through the tile indices at each bank boundary, pixel drawn in the first row
	task automatic test_tile_banks();
		logic [BYTE_W-1:0] tile_ids [5] = '{8'd44, 8'd45, 8'd139, 8'd204, 8'd255};
		logic [BYTE_W-1:0] row_byte;
		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
		send_item(CMD_MAP, ADDR_W'(LAYOUT_BASE), 8'h00, 8'h00, 8'h00, 16'h0000);
		foreach (tile_ids[k]) begin
			// all set and all clear first, then random bytes
			row_byte = (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : BYTE_W'($urandom_range(0, 255));
			send_item(CMD_MAP, 13'd0, tile_ids[k], 8'hFF, 8'hFF, 16'hFFFF);
			send_item(bank_for_tile(tile_ids[k]), ADDR_W'(tile_ids[k] * 8), row_byte,
				SCR_W'($urandom_range(0, 255)), SCR_W'($urandom_range(0, 255)),
				COLOR_W'($urandom_range(0, 65535)));
			send_render(SCR_W'($urandom_range(0, 7)), 8'd0, (k % 2) ? 16'hFFFF : 16'h0000);
		end
	endtask

	// writes past each bank's end, top of map, unused commands, rows off screen
	task automatic test_write_corners();
		send_item(CMD_BANK_ONE, ADDR_W'(BANK_ONE_BYTES_DEF), 8'hA5, 8'h00, 8'h00, 16'h0000);
		send_item(CMD_BANK_TWO, ADDR_W'(BANK_TWO_BYTES_DEF), 8'h5A, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(CMD_BANK_THREE, 13'h1FFF, 8'hFF, 8'h80, 8'h7F, 16'h8000);
		send_item(CMD_MAP, 13'h1FFF, 8'h00, 8'h01, 8'hFE, 16'h7FFF);
		send_item(CMD_SPARE_LO, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
		send_item(CMD_SPARE_HI, 13'h0000, 8'h00, 8'h00, 8'h00, 16'h0000);
		send_item(CMD_RENDER, 13'h0AAA, 8'h55, 8'hFF, SCR_W'(SCREEN_H), 16'hFFFF);
		send_item(CMD_RENDER, 13'h1555, 8'hAA, 8'h00, 8'hFF, 16'h0000);
	endtask

	// receiver holds off long enough for the pipe to fill and push back on requests,
	// then the sender waits until every response has come home
	task automatic test_backpressure();
		drain_pipeline();
		sender_gaps_on = 1'b0;
		receiver_stalls_on = 1'b0;
		hold_request = HOLD_CYCLES;
		repeat (40) send_random_render();
		drain_pipeline();
	endtask

	// one register setting, then a mix of renders (mostly), stray writes and unused codes
	task automatic run_random_phase(input logic [CAM_W-1:0] cx, input logic [CAM_W-1:0] cy,
			input logic [COLOR_W-1:0] colour, input int unsigned quota, input bit tx_gaps,
			input bit rx_stalls);
		int unsigned      first_item, roll;
		logic [CMD_W-1:0] target;
		drain_pipeline();
		write_register(CFG_CAM_X, CFG_DATA_W'(cx));
		write_register(CFG_CAM_Y, CFG_DATA_W'(cy));
		write_register(CFG_DRAW_COLOR, colour);
		sender_gaps_on = tx_gaps;
		receiver_stalls_on = rx_stalls;
		first_item = items_sent;
		while (items_sent - first_item < quota) begin
			roll = $urandom_range(0, 99);
			if (roll < 65) begin
				send_random_render();
			end else if (roll < 93) begin
				target = CMD_W'($urandom_range(CMD_BANK_ONE, CMD_MAP));
				send_item(target,
					ADDR_W'($urandom_range(0, 1) ? $urandom_range(0, mem_bytes(target) - 1)
						: $urandom_range(0, 8191)),
					BYTE_W'($urandom_range(0, 255)), SCR_W'($urandom_range(0, 255)),
					SCR_W'($urandom_range(0, 255)), COLOR_W'($urandom_range(0, 65535)));
			end else begin
				send_item(CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI)),
					ADDR_W'($urandom_range(0, 8191)), BYTE_W'($urandom_range(0, 255)),
					SCR_W'($urandom_range(0, 255)), SCR_W'($urandom_range(0, 255)),
					COLOR_W'($urandom_range(0, 65535)));
			end
		end
	endtask

	// camera and colour extremes, then settings that straddle the layout end
	task automatic test_camera_sweep();
		run_random_phase(12'd0, 12'd0, 16'hFFFF, 300, 1'b1, 1'b1);
		// whole screen beyond the layout, every pixel misses
		run_random_phase(12'hFFF, 12'hFFF, 16'h0000, 100, 1'b0, 1'b0);
		run_random_phase(12'hFFF, 12'd0, COLOR_W'($urandom_range(0, 65535)), 300, 1'b1, 1'b0);
		// lower rows fall past the end of the map memory
		run_random_phase(CAM_W'($urandom_range(0, 4095)), CAM_W'($urandom_range(2300, 2500)),
			COLOR_W'($urandom_range(0, 65535)), 300, 1'b0, 1'b1);
		repeat (3)
			run_random_phase(CAM_W'($urandom_range(0, 4095)), CAM_W'($urandom_range(0, 2600)),
				COLOR_W'($urandom_range(0, 65535)), 300, 1'b1, 1'b1);
	endtask

	// response side: stall runs of random length, plus the long hold-off when asked
	initial begin : response_side
		int unsigned stall_left;
		stall_left = 0;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request != 0) begin
				stall_left = hold_request;
				hold_request = 0;
			end
			if (stall_left != 0) begin
				rsp_stall = 1'b1;
				stall_left--;
			end else begin
				rsp_stall = 1'b0;
				if (receiver_stalls_on)
					stall_left = pick_gap();
			end
		end
	end

	// every response transaction is matched against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch($sformatf("response with nothing pending: pixel %h hit %b",
					pixel_out, tile_hit));
			end else begin
				oldest_expected = pending_pixels.pop_front();
				if (pixel_out !== oldest_expected.pixel)
					report_mismatch($sformatf("pixel_out %h, expected %h",
						pixel_out, oldest_expected.pixel));
				if (tile_hit !== oldest_expected.hit)
					report_mismatch($sformatf("tile_hit %b, expected %b",
						tile_hit, oldest_expected.hit));
			end
		end
	end

	// safety net in case the block hangs
	initial begin : watchdog
		#RUN_LIMIT_NS;
		$display("simulation failed");
		$finish;
	end

	initial begin : test_sequence
		// every input known from time zero, reset held low before the tests start
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = CFG_CAM_X;
		cfg_data = '0;
		req_valid = 1'b0;
		command = CMD_RENDER;
		address = '0;
		data = '0;
		pixel_x = '0;
		pixel_y = '0;
		background_pixel = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_tile_banks();
		test_write_corners();
		test_backpressure();
		test_camera_sweep();
		drain_pipeline();

		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
